### rtl/core/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg: shared types and constants of the transfer run coalescer
// Field widths, alignment and address masks, queue sizing, item and result.
// ----------------------------------------------------------------------------
package trc_pkg;

    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 32;
    localparam int IDX_W      = 16;
    localparam int ALIGN_BITS = 12;
    localparam int ADDR_BITS  = 48;

    localparam logic [ADDR_W-1:0] ADDR_MASK =
        ADDR_W'(64'hFFFF_FFFF_FFFF_FFFF >> (64 - ADDR_BITS));
    localparam logic [ADDR_W-1:0] ALIGN_MASK_A =
        ADDR_W'((64'd1 << ALIGN_BITS) - 64'd1);
    localparam logic [SIZE_W-1:0] ALIGN_MASK_S =
        SIZE_W'((64'd1 << ALIGN_BITS) - 64'd1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DESC  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] base_off;
        logic              is_null;
        logic              is_write;
        logic              last;
    } trc_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] offset;
        logic              dir_write;
        logic              last_of_item;
    } trc_result_t;

endpackage

### rtl/core/transfer_run_coalescer_core.sv
// ----------------------------------------------------------------------------
// transfer_run_coalescer_core: tensor slot to transfer descriptor coalescer
// A slot taken at the input is written into the queue register, and a result
// that the run engine forms from it is written into the output register.
// The run engine takes one slot per cycle while the output is not stalled;
// a last slot holds it through PH_MAIN and PH_LAST, and through PH_DONE as
// well when a good run is still open before the done status. rst_n clears
// queue, run state and shard_size.
// ----------------------------------------------------------------------------
module transfer_run_coalescer_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [trc_pkg::SIZE_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [trc_pkg::ADDR_W-1:0] dev_addr,
    input  logic [trc_pkg::SIZE_W-1:0] tensor_size,
    input  logic [trc_pkg::IDX_W-1:0]  shard_index,
    input  logic                       is_write,
    input  logic                       last_slot,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 kind,
    output logic [trc_pkg::ADDR_W-1:0] run_addr,
    output logic [trc_pkg::SIZE_W-1:0] run_size,
    output logic [trc_pkg::ADDR_W-1:0] run_offset,
    output logic                       dir_write,
    output logic                       last_of_item
);

    logic                 push_valid;
    logic                 push_ready;
    trc_pkg::trc_item_t   push_item;
    logic                 pop_valid;
    logic                 pop_ready;
    trc_pkg::trc_item_t   pop_item;
    trc_pkg::trc_result_t result;

    trc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .dev_addr    (dev_addr),
        .tensor_size (tensor_size),
        .shard_index (shard_index),
        .is_write    (is_write),
        .last_slot   (last_slot),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    trc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    trc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .item      (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign kind         = result.kind;
    assign run_addr     = result.addr;
    assign run_size     = result.size;
    assign run_offset   = result.offset;
    assign dir_write    = result.dir_write;
    assign last_of_item = result.last_of_item;

endmodule

### rtl/core/trc_front.sv
// ----------------------------------------------------------------------------
// trc_front: slot intake and classification
// Holds shard_size, forms the shard base offset and flags empty slots.
// ----------------------------------------------------------------------------
module trc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [trc_pkg::SIZE_W-1:0]   cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [trc_pkg::ADDR_W-1:0]   dev_addr,
    input  logic [trc_pkg::SIZE_W-1:0]   tensor_size,
    input  logic [trc_pkg::IDX_W-1:0]    shard_index,
    input  logic                         is_write,
    input  logic                         last_slot,
    output logic                         push_valid,
    input  logic                         push_ready,
    output trc_pkg::trc_item_t           push_item
);

    logic [trc_pkg::SIZE_W-1:0]                shard_size_reg;
    logic [trc_pkg::ADDR_W-1:0]                addr_masked;
    logic [trc_pkg::SIZE_W+trc_pkg::IDX_W-1:0] base_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shard_size_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            shard_size_reg <= cfg_wr_data;
        end
    end

    assign addr_masked = dev_addr & trc_pkg::ADDR_MASK;
    assign base_prod   = shard_size_reg * shard_index;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    always_comb
    begin
        push_item.addr     = addr_masked;
        push_item.size     = tensor_size;
        push_item.base_off = trc_pkg::ADDR_W'(base_prod);
        push_item.is_null  = (tensor_size == '0) || (addr_masked == '0);
        push_item.is_write = is_write;
        push_item.last     = last_slot;
    end

endmodule

### rtl/core/trc_queue.sv
// ----------------------------------------------------------------------------
// trc_queue: item queue between intake and run engine
// Small register FIFO; decouples stalls of the two sides.
// ----------------------------------------------------------------------------
module trc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  trc_pkg::trc_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output trc_pkg::trc_item_t pop_item
);

    trc_pkg::trc_item_t entry_reg [trc_pkg::QUEUE_DEPTH];

    logic [trc_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [trc_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [trc_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [trc_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [trc_pkg::QCNT_W-1:0] count_reg;
    logic [trc_pkg::QCNT_W-1:0] count_next;
    logic                       do_push;
    logic                       do_pop;

    assign push_ready = (count_reg != trc_pkg::QCNT_W'(trc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == trc_pkg::QPTR_W'(trc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == trc_pkg::QPTR_W'(trc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/core/trc_back.sv
// ----------------------------------------------------------------------------
// trc_back: run engine
// Extends, closes and checks runs; emits at most one result per cycle
// into the output register, only while that register is free or being read.
// ----------------------------------------------------------------------------
module trc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  trc_pkg::trc_item_t  item,
    output logic                out_valid,
    input  logic                out_ready,
    output trc_pkg::trc_result_t result
);

    typedef enum logic [1:0] {
        PH_MAIN,
        PH_LAST,
        PH_DONE
    } phase_t;

    phase_t                     phase_reg;
    phase_t                     phase_next;
    logic                       mid_reg;
    logic                       mid_next;
    logic                       ab_reg;
    logic                       ab_next;
    logic [trc_pkg::ADDR_W-1:0] run_addr_reg;
    logic [trc_pkg::ADDR_W-1:0] run_addr_next;
    logic [trc_pkg::SIZE_W-1:0] run_len_reg;
    logic [trc_pkg::SIZE_W-1:0] run_len_next;
    logic [trc_pkg::ADDR_W-1:0] run_off_reg;
    logic [trc_pkg::ADDR_W-1:0] run_off_next;
    logic [trc_pkg::ADDR_W-1:0] nfo_reg;
    logic [trc_pkg::ADDR_W-1:0] nfo_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    trc_pkg::trc_result_t       res_reg;
    trc_pkg::trc_result_t       res_next;

    logic                       first;
    logic [trc_pkg::SIZE_W-1:0] e_len;
    logic [trc_pkg::ADDR_W-1:0] e_off;
    logic [trc_pkg::ADDR_W-1:0] e_nfo;
    logic                       e_ab;
    logic                       has_run;
    logic                       bad;
    logic                       contig;
    logic [trc_pkg::ADDR_W-1:0] run_end;
    logic [trc_pkg::SIZE_W:0]   len_sum;
    logic [trc_pkg::SIZE_W-1:0] len_sat;
    logic                       out_free;
    logic                       advance;
    logic                       emit;
    logic                       finish;
    trc_pkg::trc_result_t       close_res;
    trc_pkg::trc_result_t       done_res;

    assign first   = !mid_reg;
    assign e_len   = first ? '0 : run_len_reg;
    assign e_off   = first ? '0 : run_off_reg;
    assign e_nfo   = first ? item.base_off : nfo_reg;
    assign e_ab    = first ? 1'b0 : ab_reg;
    assign has_run = (e_len != '0);
    assign bad     = ((run_addr_reg & trc_pkg::ALIGN_MASK_A) != '0) ||
                     ((e_len & trc_pkg::ALIGN_MASK_S) != '0);
    assign run_end = (run_addr_reg + trc_pkg::ADDR_W'(e_len)) & trc_pkg::ADDR_MASK;
    assign contig  = has_run && (run_end == item.addr);
    assign len_sum = {1'b0, e_len} + {1'b0, item.size};
    assign len_sat = len_sum[trc_pkg::SIZE_W] ? '1 : len_sum[trc_pkg::SIZE_W-1:0];

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = pop_valid && out_free;

    always_comb
    begin
        close_res.kind         = bad ? trc_pkg::KIND_ABORT : trc_pkg::KIND_DESC;
        close_res.addr         = run_addr_reg;
        close_res.size         = e_len;
        close_res.offset       = e_off;
        close_res.dir_write    = item.is_write;
        close_res.last_of_item = 1'b0;

        done_res.kind          = trc_pkg::KIND_DONE;
        done_res.addr          = '0;
        done_res.size          = '0;
        done_res.offset        = '0;
        done_res.dir_write     = item.is_write;
        done_res.last_of_item  = 1'b1;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        mid_next      = mid_reg;
        ab_next       = ab_reg;
        run_addr_next = run_addr_reg;
        run_len_next  = run_len_reg;
        run_off_next  = run_off_reg;
        nfo_next      = nfo_reg;
        res_next      = res_reg;
        emit          = 1'b0;
        finish        = 1'b0;
        pop_ready     = 1'b0;

        if (advance)
        begin
            unique case (phase_reg)
                PH_MAIN:
                begin
                    mid_next     = 1'b1;
                    ab_next      = e_ab;
                    run_len_next = e_len;
                    run_off_next = e_off;
                    nfo_next     = e_nfo;
                    res_next     = close_res;
                    res_next.last_of_item = !item.last || bad;
                    if (!e_ab)
                    begin
                        if (item.is_null)
                        begin
                            emit         = has_run;
                            run_len_next = '0;
                            if (has_run && bad)
                            begin
                                ab_next = 1'b1;
                            end
                            else
                            begin
                                nfo_next = e_nfo + trc_pkg::ADDR_W'(item.size);
                            end
                        end
                        else if (contig)
                        begin
                            run_len_next = len_sat;
                            nfo_next     = e_nfo + trc_pkg::ADDR_W'(item.size);
                        end
                        else
                        begin
                            emit = has_run;
                            if (has_run && bad)
                            begin
                                ab_next      = 1'b1;
                                run_len_next = '0;
                            end
                            else
                            begin
                                run_addr_next = item.addr;
                                run_len_next  = item.size;
                                run_off_next  = e_nfo;
                                nfo_next      = e_nfo + trc_pkg::ADDR_W'(item.size);
                            end
                        end
                    end
                    if (item.last)
                    begin
                        phase_next = PH_LAST;
                    end
                    else
                    begin
                        pop_ready = 1'b1;
                    end
                end
                PH_LAST:
                begin
                    if (ab_reg)
                    begin
                        finish = 1'b1;
                    end
                    else if (has_run)
                    begin
                        emit     = 1'b1;
                        res_next = close_res;
                        res_next.last_of_item = bad;
                        if (bad)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    else
                    begin
                        emit     = 1'b1;
                        res_next = done_res;
                        finish   = 1'b1;
                    end
                end
                PH_DONE:
                begin
                    emit     = 1'b1;
                    res_next = done_res;
                    finish   = 1'b1;
                end
                default:
                begin
                    finish = 1'b1;
                end
            endcase

            if (finish)
            begin
                mid_next     = 1'b0;
                ab_next      = 1'b0;
                run_len_next = '0;
                phase_next   = PH_MAIN;
                pop_ready    = 1'b1;
            end
        end

        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        if (!(advance && emit))
        begin
            res_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAIN;
            mid_reg       <= 1'b0;
            ab_reg        <= 1'b0;
            run_addr_reg  <= '0;
            run_len_reg   <= '0;
            run_off_reg   <= '0;
            nfo_reg       <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            mid_reg       <= mid_next;
            ab_reg        <= ab_next;
            run_addr_reg  <= run_addr_next;
            run_len_reg   <= run_len_next;
            run_off_reg   <= run_off_next;
            nfo_reg       <= nfo_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

### rtl/core/trc_checker.sv
// ----------------------------------------------------------------------------
// trc_checker: port-level checks of the coalescer
// Output hold under stall, descriptor alignment and result framing.
// ----------------------------------------------------------------------------
module trc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [1:0]                 kind,
    input logic [trc_pkg::ADDR_W-1:0] run_addr,
    input logic [trc_pkg::SIZE_W-1:0] run_size,
    input logic [trc_pkg::ADDR_W-1:0] run_offset,
    input logic                       dir_write,
    input logic                       last_of_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(run_addr)
            && $stable(run_size) && $stable(run_offset) && $stable(dir_write)
            && $stable(last_of_item))
        else $error("output item changed while stalled");

    a_desc_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == trc_pkg::KIND_DESC |->
            run_size != '0 && (run_addr & trc_pkg::ALIGN_MASK_A) == '0
            && (run_size & trc_pkg::ALIGN_MASK_S) == '0)
        else $error("descriptor is empty or misaligned");

    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == trc_pkg::KIND_DONE |->
            run_addr == '0 && run_size == '0 && run_offset == '0)
        else $error("done status carries run fields");

    a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == trc_pkg::KIND_DONE || kind == trc_pkg::KIND_ABORT)
            |-> last_of_item)
        else $error("status is not the final result of its item");

endmodule

bind transfer_run_coalescer_core trc_checker u_trc_checker (.*);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for transfer_run_coalescer_core
// Feeds tensor slots through a valid/ready driver with random gaps. A clocked
// monitor predicts the runs, shard ends and aborts of every accepted item and
// checks each result field by field against them. shard_size is changed
// between phases. A long receiver hold makes the block stall its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LONG_HOLD      = 120;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_SLOTS    = 64;
    localparam int PHASES         = 6;

    localparam int ADDR_W     = trc_pkg::ADDR_W;
    localparam int SIZE_W     = trc_pkg::SIZE_W;
    localparam int IDX_W      = trc_pkg::IDX_W;
    localparam int ALIGN_BITS = trc_pkg::ALIGN_BITS;
    localparam logic [ADDR_W-1:0] ADDR_MASK    = trc_pkg::ADDR_MASK;
    localparam logic [ADDR_W-1:0] ALIGN_MASK_A = trc_pkg::ALIGN_MASK_A;
    localparam logic [SIZE_W-1:0] ALIGN_MASK_S = trc_pkg::ALIGN_MASK_S;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [IDX_W-1:0]  idx;
        logic              wr;
        logic              last;
    } slot_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [SIZE_W-1:0] cfg_wr_data = '0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [ADDR_W-1:0] dev_addr    = '0;
    logic [SIZE_W-1:0] tensor_size = '0;
    logic [IDX_W-1:0]  shard_index = '0;
    logic              is_write    = 1'b0;
    logic              last_slot   = 1'b0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] run_addr;
    logic [SIZE_W-1:0] run_size;
    logic [ADDR_W-1:0] run_offset;
    logic              dir_write;
    logic              last_of_item;

    transfer_run_coalescer_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .dev_addr     (dev_addr),
        .tensor_size  (tensor_size),
        .shard_index  (shard_index),
        .is_write     (is_write),
        .last_slot    (last_slot),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .run_addr     (run_addr),
        .run_size     (run_size),
        .run_offset   (run_offset),
        .dir_write    (dir_write),
        .last_of_item (last_of_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    slot_t                slot_queue[$];
    trc_pkg::trc_result_t expected_runs[$];
    int          slots_pushed   = 0;
    int          slots_taken    = 0;
    int          results_seen   = 0;
    int          mismatches     = 0;
    int          n_desc         = 0;
    int          n_done         = 0;
    int          n_abort        = 0;
    int          n_cfg          = 0;
    int          stuck_cycles   = 0;
    bit          item_taken     = 1'b0;
    bit          no_idle        = 1'b0;
    int          send_gap       = 0;
    int          hold_left      = 0;
    bit          long_hold_done = 1'b0;

    // coalescer state as the monitor sees it
    logic [SIZE_W-1:0]    cfg_shard_size = '0;
    logic [ADDR_W-1:0]    run_start      = '0;
    logic [SIZE_W-1:0]    run_len        = '0;
    logic [ADDR_W-1:0]    run_file_off   = '0;
    logic [ADDR_W-1:0]    next_off       = '0;
    bit                   in_shard       = 1'b0;
    bit                   shard_dead     = 1'b0;
    trc_pkg::trc_result_t step_out[3];
    int                   step_n         = 0;

    // slot generator state
    int                gen_left = 0;
    logic [ADDR_W-1:0] gen_end  = '0;
    logic [IDX_W-1:0]  gen_idx  = '0;
    logic              gen_wr   = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    task automatic emit(input trc_pkg::kind_t k, input logic [ADDR_W-1:0] a,
                        input logic [SIZE_W-1:0] s, input logic [ADDR_W-1:0] o,
                        input logic dir);
        step_out[step_n] = '{kind: k, addr: a, size: s, offset: o,
                             dir_write: dir, last_of_item: 1'b0};
        step_n++;
    endtask

    task automatic close_run(input logic dir, output bit kept);
        kept = 1'b1;
        if (run_len != '0)
        begin
            if ((run_start & ALIGN_MASK_A) != '0 || (run_len & ALIGN_MASK_S) != '0)
            begin
                emit(trc_pkg::KIND_ABORT, run_start, run_len, run_file_off, dir);
                shard_dead = 1'b1;
                kept = 1'b0;
            end
            else
            begin
                emit(trc_pkg::KIND_DESC, run_start, run_len, run_file_off, dir);
                run_start = '0;
            end
            run_len = '0;
        end
    endtask

    task automatic coalesce_slot(input slot_t s);
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W:0]   merged;
        bit                kept;
        addr = s.addr & ADDR_MASK;
        step_n = 0;
        if (!in_shard)
        begin
            next_off = ADDR_W'(cfg_shard_size) * ADDR_W'(s.idx);
            run_len = '0;
            run_start = '0;
            run_file_off = '0;
            shard_dead = 1'b0;
            in_shard = 1'b1;
        end
        if (!shard_dead)
        begin
            if (s.size == '0 || addr == '0)
                close_run(s.wr, kept);
            else if (run_len != '0 &&
                     ((run_start + ADDR_W'(run_len)) & ADDR_MASK) == addr)
            begin
                merged = {1'b0, run_len} + {1'b0, s.size};
                run_len = merged[SIZE_W] ? '1 : merged[SIZE_W-1:0];
            end
            else
            begin
                close_run(s.wr, kept);
                if (kept)
                begin
                    run_start = addr;
                    run_len = s.size;
                    run_file_off = next_off;
                end
            end
            if (!shard_dead)
                next_off = next_off + ADDR_W'(s.size);
        end
        if (s.last)
        begin
            if (!shard_dead)
            begin
                close_run(s.wr, kept);
                if (kept)
                    emit(trc_pkg::KIND_DONE, '0, '0, '0, s.wr);
            end
            in_shard = 1'b0;
            shard_dead = 1'b0;
            run_len = '0;
            run_start = '0;
            run_file_off = '0;
        end
        if (step_n > 0)
            step_out[step_n-1].last_of_item = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_runs.push_back(step_out[i]);
    endtask

    task automatic check_field(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic push_slot(input logic [ADDR_W-1:0] a, input logic [SIZE_W-1:0] s,
                             input logic [IDX_W-1:0] idx, input logic wr,
                             input logic last);
        slot_queue.push_back(slot_t'{addr: a, size: s, idx: idx, wr: wr, last: last});
        slots_pushed++;
    endtask

    task automatic add_random_slots(input int count);
        logic [ADDR_W-1:0] a;
        logic [SIZE_W-1:0] sz;
        logic              wr;
        int                r;
        repeat (count)
        begin
            if (gen_left == 0)
            begin
                gen_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                       : $urandom_range(1, 8);
                r = $urandom_range(0, 9);
                gen_idx = (r == 0) ? '0 : (r == 1) ? '1 : IDX_W'($urandom);
                gen_wr = 1'($urandom);
                gen_end = '0;
            end
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 6) == 0)
                sz = SIZE_W'($urandom) & ~ALIGN_MASK_S;
            else
                sz = SIZE_W'($urandom_range(1, 16)) << ALIGN_BITS;
            if ((r < 45 || (r >= 90 && r < 94)) && gen_end != '0)
                a = gen_end;
            else
                a = {16'($urandom), 20'($urandom), 12'h000};
            wr = ($urandom_range(0, 19) == 0) ? !gen_wr : gen_wr;
            if (r >= 70 && r < 78)
                sz = '0;
            else if (r >= 78 && r < 85)
                a = '0;
            else if (r >= 85 && r < 90)
            begin
                a = {16'($urandom), 32'($urandom)};
                sz = $urandom_range(1, 32'h0000_4000);
            end
            else if (r >= 90 && r < 94)
                sz = {1'b1, 19'($urandom), 12'h000};
            if (r >= 94)
                push_slot({16'($urandom), 32'($urandom)}, $urandom, IDX_W'($urandom),
                          1'($urandom), 1'($urandom));
            else
                push_slot(a, sz, gen_idx, wr, gen_left == 1);
            if (a != '0 && sz != '0)
                gen_end = a + ADDR_W'(sz);
            gen_left--;
        end
    endtask

    task automatic wait_drained();
        while (slots_taken != slots_pushed || expected_runs.size() != 0)
            @(negedge clk);
        // let ignored items clear the pipeline
        repeat (8) @(negedge clk);
    endtask

    task automatic write_shard_size(input logic [SIZE_W-1:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        n_cfg++;
    endtask

    // sender
    always @(negedge clk)
    begin : sender
        slot_t cur;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || item_taken)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (slot_queue.size() != 0)
            begin
                cur = slot_queue.pop_front();
                dev_addr <= cur.addr;
                tensor_size <= cur.size;
                shard_index <= cur.idx;
                is_write <= cur.wr;
                last_slot <= cur.last;
                in_valid <= 1'b1;
                send_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin : receiver
        int g;
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (!long_hold_done && slots_taken >= 100)
        begin
            // hold off long enough to back up the block into its input
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            g = pick_gap();
            if (g == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                hold_left = g - 1;
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin : monitor
        trc_pkg::trc_result_t want;
        if (!rst_n)
            item_taken <= 1'b0;
        else
        begin
            item_taken <= in_valid && in_ready;
            if (cfg_wr_en)
                cfg_shard_size = cfg_wr_data;
            if (in_valid && in_ready)
            begin
                coalesce_slot(slot_t'{addr: dev_addr, size: tensor_size, idx: shard_index,
                                      wr: is_write, last: last_slot});
                slots_taken++;
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_runs.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got kind %0d addr %h",
                             $time, kind, run_addr);
                    mismatches++;
                end
                else
                begin
                    want = expected_runs.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("run_addr", want.addr, run_addr);
                    check_field("run_size", want.size, run_size);
                    check_field("run_offset", want.offset, run_offset);
                    check_field("dir_write", want.dir_write, dir_write);
                    check_field("last_of_item", want.last_of_item, last_of_item);
                end
                case (kind)
                    trc_pkg::KIND_DESC:  n_desc++;
                    trc_pkg::KIND_DONE:  n_done++;
                    trc_pkg::KIND_ABORT: n_abort++;
                    default:    ;
                endcase
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, expected_runs.size());
                $display("[transfer_run_coalescer_core] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [SIZE_W-1:0] next_size;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_shard_size(32'hFFFF_FFFF);
        // merge, ghost close, null slot, new runs, last with two results
        push_slot(48'h0000_0000_1000, 32'h0000_1000, 16'hFFFF, 1'b1, 1'b0);
        push_slot(48'h0000_0000_2000, 32'h0000_3000, 16'hFFFF, 1'b1, 1'b0);
        push_slot(48'h0000_0000_9000, 32'h0000_0000, 16'hFFFF, 1'b1, 1'b0);
        push_slot(48'h0000_0000_0000, 32'h0000_2000, 16'hFFFF, 1'b1, 1'b0);
        push_slot(48'h0000_0001_0000, 32'h0000_2000, 16'hFFFF, 1'b1, 1'b0);
        push_slot(48'h0000_0002_0000, 32'h0000_1000, 16'hFFFF, 1'b1, 1'b0);
        push_slot(48'h0000_0002_1000, 32'h0000_1000, 16'hFFFF, 1'b1, 1'b1);
        // address wrap into a saturated run, aborted on the last slot
        push_slot(48'hFFFF_FFFF_F000, 32'hFFFF_F000, 16'h0000, 1'b0, 1'b0);
        push_slot(48'h0000_FFFF_E000, 32'hFFFF_F000, 16'h0000, 1'b0, 1'b0);
        push_slot(48'h0000_0000_0000, 32'h0000_0000, 16'h0000, 1'b0, 1'b1);
        // misaligned start aborts mid shard, rest of the shard dropped
        push_slot(48'h0000_0000_1234, 32'h0000_1000, 16'h0001, 1'b1, 1'b0);
        push_slot(48'h0000_0000_5000, 32'h0000_1000, 16'h0001, 1'b1, 1'b0);
        push_slot(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0);
        push_slot(48'h0000_0000_0000, 32'h0000_0000, 16'h0001, 1'b1, 1'b0);
        push_slot(48'h0000_0000_6000, 32'h0000_1000, 16'h0001, 1'b1, 1'b1);
        // single slot shard with misaligned length
        push_slot(48'h0000_0000_3000, 32'h0000_0800, 16'h0002, 1'b0, 1'b1);
        // last slot breaks the run: descriptor, descriptor, done
        push_slot(48'h0000_0000_8000, 32'h0000_1000, 16'h0007, 1'b0, 1'b0);
        push_slot(48'h0000_0010_0000, 32'h0000_2000, 16'h0007, 1'b0, 1'b1);
        // ghost last slot with nothing open
        push_slot(48'h0000_ABCD_E000, 32'h0000_0000, 16'h0003, 1'b1, 1'b1);
        // merged odd lengths abort at the end
        push_slot(48'h0000_0000_4000, 32'h0000_1000, 16'h0004, 1'b1, 1'b0);
        push_slot(48'h0000_0000_5000, 32'h0000_0FFF, 16'h0004, 1'b1, 1'b0);
        push_slot(48'h0000_0000_5FFF, 32'h0000_1000, 16'h0004, 1'b1, 1'b0);
        push_slot(48'h0000_0000_0000, 32'h0000_0000, 16'h0004, 1'b1, 1'b1);
        // leave a shard open across the next shard_size change
        push_slot(48'h0000_0040_0000, 32'h0000_1000, 16'h0005, 1'b0, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       next_size = 32'h0000_0000;
                1:       next_size = 32'h0000_0001;
                2:       next_size = 32'h0010_0000;
                3:       next_size = $urandom;
                4:       next_size = 32'hFFFF_FFFF;
                default: next_size = SIZE_W'($urandom) & ~ALIGN_MASK_S;
            endcase
            write_shard_size(next_size);
            no_idle = (p == 2);
            add_random_slots(PHASE_SLOTS);
        end
        wait_drained();

        $display("covered %0d slots over %0d shard_size settings", slots_taken, n_cfg);
        $display("results: %0d descriptors, %0d shard ends, %0d aborts",
                 n_desc, n_done, n_abort);
        if (mismatches == 0)
            $display("[transfer_run_coalescer_core] OK");
        else
            $display("[transfer_run_coalescer_core] ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/core/trc_pkg.sv
rtl/core/trc_front.sv
rtl/core/trc_queue.sv
rtl/core/trc_back.sv
rtl/core/transfer_run_coalescer_core.sv
rtl/core/trc_checker.sv
tb/tb_top.sv
